/* sv/itp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer token parser package
// Parse modes, keyword codes and character-class helpers.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int CHAR_W  = 8;
   localparam int LIMIT_W = 31;
   localparam int VALUE_W = 32;
   localparam int ACC_W   = 36;
   localparam int WARN_W  = 2;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;

   localparam logic [VALUE_W-1:0] OPAQUE_ALPHA = 32'hff00_0000;
   localparam logic [3:0]         ALPHA_MAX_DIGITS = 4'd6;

   // Warning codes
   localparam logic [WARN_W-1:0] WARN_NONE     = 2'd0;
   localparam logic [WARN_W-1:0] WARN_OVERFLOW = 2'd1;
   localparam logic [WARN_W-1:0] WARN_NO_HEX   = 2'd2;

   // Keyword codes
   localparam logic [2:0] KW_TRUE  = 3'd0;
   localparam logic [2:0] KW_FALSE = 3'd1;
   localparam logic [2:0] KW_ON    = 3'd2;
   localparam logic [2:0] KW_OFF   = 3'd3;
   localparam logic [2:0] KW_YES   = 3'd4;
   localparam logic [2:0] KW_NO    = 3'd5;

   typedef enum logic [7:0] {
      MODE_START   = 8'b0000_0001,
      MODE_MINUS   = 8'b0000_0010,
      MODE_DEC     = 8'b0000_0100,
      MODE_PCT     = 8'b0000_1000,
      MODE_HEX     = 8'b0001_0000,
      MODE_KEY     = 8'b0010_0000,
      MODE_DEAD    = 8'b0100_0000,
      MODE_HEXDEAD = 8'b1000_0000
   } mode_type;

   function automatic logic [2:0] kw_len(input logic [2:0] choice);
      logic [2:0] len;
      case (choice)
         KW_TRUE:  len = 3'd4;
         KW_FALSE: len = 3'd5;
         KW_ON:    len = 3'd2;
         KW_OFF:   len = 3'd3;
         KW_YES:   len = 3'd3;
         KW_NO:    len = 3'd2;
         default:  len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic kw_val(input logic [2:0] choice);
      return (choice == KW_TRUE) || (choice == KW_ON) || (choice == KW_YES);
   endfunction

   // Byte of a keyword at a position; zero past its end
   function automatic logic [7:0] kw_char(input logic [2:0] choice,
                                          input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (choice)
         KW_TRUE: begin
            case (pos)
               3'd0:    ch = "t";
               3'd1:    ch = "r";
               3'd2:    ch = "u";
               3'd3:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (pos)
               3'd0:    ch = "f";
               3'd1:    ch = "a";
               3'd2:    ch = "l";
               3'd3:    ch = "s";
               3'd4:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         KW_ON: begin
            case (pos)
               3'd0:    ch = "o";
               3'd1:    ch = "n";
               default: ch = 8'h00;
            endcase
         end
         KW_OFF: begin
            case (pos)
               3'd0:    ch = "o";
               3'd1:    ch = "f";
               3'd2:    ch = "f";
               default: ch = 8'h00;
            endcase
         end
         KW_YES: begin
            case (pos)
               3'd0:    ch = "y";
               3'd1:    ch = "e";
               3'd2:    ch = "s";
               default: ch = 8'h00;
            endcase
         end
         KW_NO: begin
            case (pos)
               3'd0:    ch = "n";
               3'd1:    ch = "o";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Hex digit value in [3:0], valid flag in [4]
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if ((c >= "0") && (c <= "9")) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end else if ((c >= "a") && (c <= "f")) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end else if ((c >= "A") && (c <= "F")) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'b0_0000;
   endfunction

endpackage

/* sv/integer_token_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer token parser unit
// Parses decimal, '#' hex colour and boolean keyword tokens byte by byte.
// ----------------------------------------------------------------------------
// One token byte is taken per cycle while the input register is not holding
// back a last byte for the result side. A byte lands in an input register;
// from there it updates the token state (one constant multiply-by-ten and
// add, one limit compare) and, on the last byte of a token, loads the result
// register. Bytes that are not last never wait on the result side; a last
// byte waits only while an earlier result is still held. Only the last byte
// of a token yields a result.
// ----------------------------------------------------------------------------
module integer_token_parser_unit
   import itp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CHAR_W-1:0]         req_character,
   input  logic                      req_last_char,
   input  logic                      req_token_quoted,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_is_percent,
   output logic                      rsp_accepted,
   output logic [WARN_W-1:0]         rsp_warning,
   input  logic                      csr_write_enable,
   input  logic [LIMIT_W-1:0]        csr_write_data
);

   logic [LIMIT_W-1:0] limit_ff;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;
   logic              in_quoted_ff;

   // Token state
   logic             token_start_ff, token_start_in;
   mode_type         mode_ff, mode_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [3:0]       hex_cnt_ff, hex_cnt_in;
   logic             pct_ff, pct_in;
   logic             ovf_ff, ovf_in;
   logic [2:0]       pos_ff, pos_in;
   logic [2:0]       kw_ff, kw_in;
   logic             kw_alive_ff, kw_alive_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_pct_ff, rsp_pct_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic [WARN_W-1:0]  rsp_warn_ff, rsp_warn_in;

   logic       advance;
   logic       load_rsp;
   logic       req_take;

   // Per-byte next values before the end-of-token clear
   mode_type         tk_mode;
   logic [ACC_W-1:0] tk_acc;
   logic             tk_neg;
   logic [3:0]       tk_hex_cnt;
   logic             tk_pct;
   logic             tk_ovf;
   logic [2:0]       tk_pos;
   logic [2:0]       tk_kw;
   logic             tk_alive;

   logic [ACC_W-1:0] dec_sum;
   logic [4:0]       hex_d;
   logic             digit;
   logic [2:0]       kw_eff;
   logic [VALUE_W-1:0] mag;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign load_rsp  = advance && in_last_ff;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Byte step
   always_comb begin
      digit   = is_digit(in_char_ff);
      hex_d   = hex_value(in_char_ff);
      dec_sum = {acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0}
                + {{(ACC_W-4){1'b0}}, in_char_ff[3:0]};
      kw_eff  = kw_ff;

      tk_mode    = mode_ff;
      tk_acc     = acc_ff;
      tk_neg     = neg_ff;
      tk_hex_cnt = hex_cnt_ff;
      tk_pct     = pct_ff;
      tk_ovf     = ovf_ff;
      tk_pos     = pos_ff;
      tk_kw      = kw_ff;
      tk_alive   = kw_alive_ff;

      if (token_start_ff && in_quoted_ff) begin
         tk_mode = MODE_DEAD;
      end else begin
         case (mode_ff)
            MODE_START, MODE_MINUS, MODE_DEC: begin
               if (digit) begin
                  tk_mode = MODE_DEC;
                  if (!ovf_ff) begin
                     tk_acc = dec_sum;
                     tk_ovf = dec_sum > {{(ACC_W-LIMIT_W){1'b0}}, limit_ff};
                  end
               end else if (mode_ff == MODE_START) begin
                  tk_mode = MODE_KEY;
                  tk_pos  = 3'd1;
                  if (in_char_ff == CHAR_MINUS) begin
                     tk_neg  = 1'b1;
                     tk_mode = MODE_MINUS;
                     tk_pos  = pos_ff;
                  end else if (in_char_ff == CHAR_HASH) begin
                     tk_mode = MODE_HEX;
                     tk_pos  = pos_ff;
                  end else if (in_char_ff == "t") begin
                     tk_kw = KW_TRUE;
                  end else if (in_char_ff == "f") begin
                     tk_kw = KW_FALSE;
                  end else if (in_char_ff == "o") begin
                     tk_kw = KW_ON;
                  end else if (in_char_ff == "y") begin
                     tk_kw = KW_YES;
                  end else if (in_char_ff == "n") begin
                     tk_kw = KW_NO;
                  end else begin
                     tk_mode = MODE_DEAD;
                  end
               end else if (mode_ff == MODE_DEC && in_char_ff == CHAR_PERCENT) begin
                  tk_pct  = 1'b1;
                  tk_mode = MODE_PCT;
               end else begin
                  tk_mode = MODE_DEAD;
               end
            end
            MODE_PCT: begin
               tk_mode = MODE_DEAD;
            end
            MODE_HEX: begin
               if (hex_d[4]) begin
                  tk_acc = {{(ACC_W-VALUE_W){1'b0}}, acc_ff[VALUE_W-5:0], hex_d[3:0]};
                  if (hex_cnt_ff != 4'hf) begin
                     tk_hex_cnt = hex_cnt_ff + 4'd1;
                  end
               end else begin
                  tk_mode = MODE_HEXDEAD;
               end
            end
            MODE_KEY: begin
               if (kw_alive_ff) begin
                  // "o" then "f" switches from on to off
                  if (kw_ff == KW_ON && pos_ff == 3'd1 && in_char_ff == "f") begin
                     kw_eff = KW_OFF;
                  end
                  tk_kw = kw_eff;
                  if (pos_ff >= kw_len(kw_eff) || kw_char(kw_eff, pos_ff) != in_char_ff) begin
                     tk_alive = 1'b0;
                  end else begin
                     tk_pos = pos_ff + 3'd1;
                  end
               end
            end
            default: begin
               tk_mode = mode_ff;
            end
         endcase
      end
   end

   // Result from the post-byte state
   always_comb begin
      mag          = tk_acc[VALUE_W-1:0];
      rsp_value_in = '0;
      rsp_pct_in   = 1'b0;
      rsp_acc_in   = 1'b0;
      rsp_warn_in  = WARN_NONE;
      case (tk_mode)
         MODE_DEC, MODE_PCT: begin
            rsp_value_in = tk_neg ? (~mag + 32'd1) : mag;
            rsp_pct_in   = tk_pct;
            rsp_acc_in   = 1'b1;
         end
         MODE_HEX: begin
            rsp_value_in = (tk_hex_cnt <= ALPHA_MAX_DIGITS) ? (mag | OPAQUE_ALPHA) : mag;
            rsp_acc_in   = 1'b1;
         end
         MODE_KEY: begin
            if (tk_alive && tk_pos == kw_len(tk_kw)) begin
               rsp_value_in = {{(VALUE_W-1){1'b0}}, kw_val(tk_kw)};
               rsp_acc_in   = 1'b1;
            end
         end
         default: begin
            rsp_acc_in = 1'b0;
         end
      endcase
      if (tk_ovf) begin
         rsp_warn_in = WARN_OVERFLOW;
      end else if ((tk_mode == MODE_HEX || tk_mode == MODE_HEXDEAD) && tk_hex_cnt == 4'd0) begin
         rsp_warn_in = WARN_NO_HEX;
      end
   end

   // Commit the byte; clear the token state after its last byte
   always_comb begin
      token_start_in = token_start_ff;
      mode_in        = mode_ff;
      acc_in         = acc_ff;
      neg_in         = neg_ff;
      hex_cnt_in     = hex_cnt_ff;
      pct_in         = pct_ff;
      ovf_in         = ovf_ff;
      pos_in         = pos_ff;
      kw_in          = kw_ff;
      kw_alive_in    = kw_alive_ff;
      if (advance) begin
         if (in_last_ff) begin
            token_start_in = 1'b1;
            mode_in        = MODE_START;
            acc_in         = '0;
            neg_in         = 1'b0;
            hex_cnt_in     = 4'd0;
            pct_in         = 1'b0;
            ovf_in         = 1'b0;
            pos_in         = 3'd0;
            kw_in          = KW_TRUE;
            kw_alive_in    = 1'b1;
         end else begin
            token_start_in = 1'b0;
            mode_in        = tk_mode;
            acc_in         = tk_acc;
            neg_in         = tk_neg;
            hex_cnt_in     = tk_hex_cnt;
            pct_in         = tk_pct;
            ovf_in         = tk_ovf;
            pos_in         = tk_pos;
            kw_in          = tk_kw;
            kw_alive_in    = tk_alive;
         end
      end
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= {LIMIT_W{1'b1}};
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         token_start_ff <= 1'b1;
         mode_ff        <= MODE_START;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         hex_cnt_ff     <= 4'd0;
         pct_ff         <= 1'b0;
         ovf_ff         <= 1'b0;
         pos_ff         <= 3'd0;
         kw_ff          <= KW_TRUE;
         kw_alive_ff    <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         token_start_ff <= token_start_in;
         mode_ff        <= mode_in;
         acc_ff         <= acc_in;
         neg_ff         <= neg_in;
         hex_cnt_ff     <= hex_cnt_in;
         pct_ff         <= pct_in;
         ovf_ff         <= ovf_in;
         pos_ff         <= pos_in;
         kw_ff          <= kw_in;
         kw_alive_ff    <= kw_alive_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff   <= req_character;
         in_last_ff   <= req_last_char;
         in_quoted_ff <= req_token_quoted;
      end
      if (load_rsp) begin
         rsp_value_ff <= rsp_value_in;
         rsp_pct_ff   <= rsp_pct_in;
         rsp_acc_ff   <= rsp_acc_in;
         rsp_warn_ff  <= rsp_warn_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_is_percent = rsp_pct_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_warning    = rsp_warn_ff;

endmodule
